>>> sv/rm_pkg.sv
// rm_pkg: shared widths, defaults and the command/status bundles that join
// the running median controller and datapath. No dependencies.
package rm_pkg;

  // Sample and median width, fixed by the stream format
  localparam int DATA_W       = 32;
  // Default number of samples the sorted store holds
  localparam int CAPACITY_DEF = 1024;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // take the incoming sample, set up the insert position
    logic rd_prev;  // read the entry just below the insert position
    logic shift;    // move the read entry up one place, step position down
    logic ins;      // write the sample at the insert position, bump count
    logic rd_mid;   // read the upper middle entry
    logic rd_lo;    // keep upper middle, read the lower middle entry
    logic out_load; // place the median in the output register
  } rm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_full; // store holds CAPACITY samples
    logic cnt_zero; // store is empty
    logic pos_one;  // insert position is 1
    logic greater;  // read entry is greater than the sample
    logic out_free; // output register can take a new result
  } rm_sts_t;

endpackage

>>> sv/running_median.sv
// running_median: top level joining rm_ctrl and rm_dpath.
// Depends on rm_pkg, rm_ctrl, rm_dpath.
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_stall, in_sample_value    | in
//  result   | out_valid, out_stall, out_median_value,| out
//           | out_store_full                         |
//
// An item's walk moves stored entries up one at a time until it reaches the
// bottom of the store or an entry not greater than the sample stops it; a
// full store skips the walk. The single-port walk sets the item's time.
// rst_n is synchronous: the store is empty and no result is pending after it.
// A result waiting on out_stall does not block the next input transaction;
// the following result waits until the output register is taken.
module running_median #(
  parameter int CAPACITY = rm_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [rm_pkg::DATA_W-1:0] in_sample_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rm_pkg::DATA_W-1:0] out_median_value,
  output logic                             out_store_full
);

  rm_pkg::rm_cmd_t cmd;
  rm_pkg::rm_sts_t sts;
  logic            busy;

  rm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  rm_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample_value  (in_sample_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_median_value (out_median_value),
    .out_store_full   (out_store_full)
  );

  assign in_stall = busy;

endmodule

>>> sv/rm_ctrl.sv
// rm_ctrl: state machine sequencing insertion and median read-out.
// Depends on rm_pkg for the command and status bundles.
module rm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  rm_pkg::rm_sts_t sts,
  output rm_pkg::rm_cmd_t cmd,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_INS,
    S_MRD_HI,
    S_MRD_LO,
    S_MED
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.cnt_full) begin
            state_nxt = S_MRD_HI;
          end else if (sts.cnt_zero) begin
            state_nxt = S_INS;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_prev = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        if (sts.greater) begin
          cmd.shift = 1'b1;
          state_nxt = sts.pos_one ? S_INS : S_RD;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_MRD_HI;
      end
      S_MRD_HI: begin
        cmd.rd_mid = 1'b1;
        state_nxt  = S_MRD_LO;
      end
      S_MRD_LO: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_MED;
      end
      S_MED: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> sv/rm_dpath.sv
// rm_dpath: sorted sample store, insert position, count, median arithmetic
// and output register. Depends on rm_pkg.
module rm_dpath #(
  parameter int CAPACITY = rm_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rm_pkg::rm_cmd_t                 cmd,
  output rm_pkg::rm_sts_t                 sts,
  input  logic signed [rm_pkg::DATA_W-1:0] in_sample_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [rm_pkg::DATA_W-1:0] out_median_value,
  output logic                            out_store_full
);

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DW     = rm_pkg::DATA_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Sorted store
  logic [DW-1:0] mem [CAPACITY];

  logic [DW-1:0]     sample_r;
  logic [ADDR_W-1:0] pos_r;
  logic [CNT_W-1:0]  count_r;
  logic              full_r;
  logic [DW-1:0]     rd_data_r;
  logic [DW-1:0]     hi_r;
  logic              out_valid_r;
  logic [DW-1:0]     out_median_r;
  logic              out_full_r;

  logic [CNT_W-1:0]  mid_cnt;
  logic [ADDR_W-1:0] mid_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [DW-1:0]     wr_data;
  logic              wr_en;
  logic [DW:0]       pair_sum;
  logic [DW:0]       pair_adj;
  logic [DW-1:0]     median;

  // Status
  always_comb begin
    sts.cnt_full = (count_r == CAP_CNT);
    sts.cnt_zero = (count_r == '0);
    sts.pos_one  = (pos_r == ADDR_W'(1));
    sts.greater  = ($signed(rd_data_r) > $signed(sample_r));
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Read address: entry below insert point, or one of the middle pair
  assign mid_cnt  = count_r >> 1;
  assign mid_addr = mid_cnt[ADDR_W-1:0];
  assign rd_en    = cmd.rd_prev | cmd.rd_mid | cmd.rd_lo;
  always_comb begin
    if (cmd.rd_prev) begin
      rd_addr = pos_r - ADDR_W'(1);
    end else if (cmd.rd_lo) begin
      rd_addr = mid_addr - ADDR_W'(1);
    end else begin
      rd_addr = mid_addr;
    end
  end

  // Write: shifted entry or the new sample, always at the insert position
  assign wr_en   = cmd.shift | cmd.ins;
  assign wr_addr = pos_r;
  assign wr_data = cmd.shift ? rd_data_r : sample_r;

  // Store ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Sample, position and upper middle holding registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample_value;
      pos_r    <= count_r[ADDR_W-1:0];
      full_r   <= sts.cnt_full;
    end else if (cmd.shift) begin
      pos_r <= pos_r - ADDR_W'(1);
    end
    if (cmd.rd_lo) begin
      hi_r <= rd_data_r;
    end
  end

  // Sample count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Median: odd count takes the middle entry, even count the mean of the
  // pair, rounded toward zero
  assign pair_sum = {hi_r[DW-1], hi_r} + {rd_data_r[DW-1], rd_data_r};
  assign pair_adj = pair_sum + {{DW{1'b0}}, pair_sum[DW]};
  assign median   = count_r[0] ? hi_r : pair_adj[DW:1];

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_median_r <= median;
      out_full_r   <= full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_median_value = out_median_r;
  assign out_store_full   = out_full_r;

endmodule

>>> sv/rm_chk.sv
// rm_chk: port-level checks on running_median, attached by bind.
// Depends on rm_pkg for the data width.
module rm_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [rm_pkg::DATA_W-1:0] in_sample_value,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [rm_pkg::DATA_W-1:0] out_median_value,
  input logic                      out_store_full
);

  logic seen_full_r;

  // Remembers that a dropped sample has been reported
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_full_r <= 1'b0;
    end else if (out_valid && out_store_full) begin
      seen_full_r <= 1'b1;
    end
  end

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_median_value)
                               && $stable(out_store_full))
    else $error("stalled result changed");

  // Items are taken one at a time: busy straight after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  // Once full the store stays full until reset
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_full_r |-> out_store_full)
    else $error("store full flag dropped");

  // An accepted sample holds no unknown bits
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !$isunknown(in_sample_value))
    else $error("unknown sample accepted");

endmodule

bind running_median rm_chk u_rm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_sample_value  (in_sample_value),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_median_value (out_median_value),
  .out_store_full   (out_store_full)
);

>>> dv/running_median_tb.sv
`timescale 1ns / 100ps
// running_median_tb: self-checking testbench for the running median block.
// Depends on rm_pkg and running_median; a directed table, then random runs.

module running_median_tb;

  localparam int DW            = rm_pkg::DATA_W;
  localparam int CAPACITY      = rm_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 1076;
  localparam int DIRECTED_ROWS = 24;
  // Longest walk through the store plus margin
  localparam int DRAIN_CYCLES  = 2 * CAPACITY + 64;
  localparam int HOLD_CYCLES   = 500;
  localparam int LIMIT_CYCLES  = 10_000_000;

  typedef struct packed {
    logic signed [DW-1:0] median;
    logic                 full;
  } median_result_t;

  typedef struct packed {
    logic signed [DW-1:0] value;
    logic                 typed_in;
    logic signed [DW-1:0] median;
    logic                 full;
  } directed_row_t;

  typedef enum int {
    MODE_WIDE,
    MODE_NARROW,
    MODE_RISING,
    MODE_FALLING,
    MODE_EXTREME
  } sample_mode_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic signed [DW-1:0] in_sample_value;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [DW-1:0] out_median_value;
  logic                 out_store_full;

  // Predictor state: sorted copy of the stored samples
  logic signed [DW-1:0] held_samples [CAPACITY];
  int                   held_count;
  median_result_t       expected_medians [$];

  int fail_count;
  int samples_sent;
  int results_seen;
  int full_results;

  // Directed rows: extremes, truncation toward zero of the even mean,
  // equal samples. Typed-in expectations only for the opening rows.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'sh8000_0000, 1'b1, 32'sh8000_0000, 1'b0},
    '{32'sh8000_0001, 1'b1, 32'sh8000_0001, 1'b0},
    '{32'sh7fff_ffff, 1'b1, 32'sh8000_0001, 1'b0},
    '{32'sh7fff_ffff, 1'b1, 32'sh0000_0000, 1'b0},
    '{32'sh0000_0000, 1'b1, 32'sh0000_0000, 1'b0},
    '{-32'sd1,        1'b1, 32'sh0000_0000, 1'b0},
    '{-32'sd1,        1'b1, -32'sd1,        1'b0},
    '{-32'sd3,        1'b1, -32'sd1,        1'b0},
    '{32'sd1,         1'b0, '0, 1'b0},
    '{32'sd2,         1'b0, '0, 1'b0},
    '{32'sh5555_5555, 1'b0, '0, 1'b0},
    '{32'shaaaa_aaaa, 1'b0, '0, 1'b0},
    '{32'sh7fff_fffe, 1'b0, '0, 1'b0},
    '{32'sh8000_0002, 1'b0, '0, 1'b0},
    '{32'sd3,         1'b0, '0, 1'b0},
    '{-32'sd2,        1'b0, '0, 1'b0},
    '{32'sd100,       1'b0, '0, 1'b0},
    '{-32'sd100,      1'b0, '0, 1'b0},
    '{32'sh0001_0000, 1'b0, '0, 1'b0},
    '{32'shffff_0000, 1'b0, '0, 1'b0},
    '{32'sd7,         1'b0, '0, 1'b0},
    '{32'sd7,         1'b0, '0, 1'b0},
    '{32'sd7,         1'b0, '0, 1'b0},
    '{-32'sd7,        1'b0, '0, 1'b0}
  };

  running_median #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_median_value(out_median_value),
    .out_store_full  (out_store_full)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Insert the sample in order unless the store is full, then give the median
  function automatic median_result_t predict_median(input logic signed [DW-1:0] value);
    median_result_t res;
    int             pos;
    longint         pair_sum;
    res.full = (held_count == CAPACITY);
    if (!res.full) begin
      pos = held_count;
      // equal samples go after the ones already held
      while (pos > 0 && held_samples[pos-1] > value) begin
        held_samples[pos] = held_samples[pos-1];
        pos--;
      end
      held_samples[pos] = value;
      held_count++;
    end
    if (held_count % 2 == 1) begin
      res.median = held_samples[held_count / 2];
    end else begin
      // wide sum, division truncates toward zero
      pair_sum   = longint'(held_samples[held_count/2 - 1]) +
                   longint'(held_samples[held_count/2]);
      res.median = DW'(pair_sum / 2);
    end
    return res;
  endfunction

  // Idle the input between transactions; quiet runs never idle
  task automatic sender_gap(input bit quiet);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!quiet) begin
      if (r >= 60 && r < 90)      gap = $urandom_range(1, 3);
      else if (r >= 90 && r < 98) gap = $urandom_range(4, 10);
      else if (r >= 98)           gap = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one sample, wait for the transaction, record what it should give
  task automatic send_sample(input logic signed [DW-1:0] value, input bit use_typed,
                             input median_result_t typed_res);
    median_result_t predicted;
    in_valid        <= 1'b1;
    in_sample_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_median(value);
    if (use_typed) predicted = typed_res;
    expected_medians = {expected_medians, predicted};
    samples_sent++;
  endtask

  // Compare one result transaction with the oldest expectation
  task automatic check_result();
    median_result_t want;
    if (expected_medians.size() == 0) begin
      $error("unexpected result: median_value %0d store_full %0b",
             out_median_value, out_store_full);
      fail_count++;
      return;
    end
    want = expected_medians.pop_front();
    if (out_median_value !== want.median) begin
      $error("median_value: expected %0d, actual %0d", want.median, out_median_value);
      fail_count++;
    end
    if (out_store_full !== want.full) begin
      $error("store_full: expected %0b, actual %0b", want.full, out_store_full);
      fail_count++;
    end
  endtask

  // Result side: random stalls in busy phases, calm phases between, two long hold-offs
  initial begin : receiver
    int  stall_left;
    int  phase_left;
    bit  calm;
    stall_left = 0;
    phase_left = 0;
    calm       = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        check_result();
        results_seen++;
        if (out_store_full) full_results++;
        // hold off long enough for the block to back up onto its input
        if (results_seen == 60 || results_seen == 300) stall_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        calm       = ($urandom_range(0, 2) == 0);
        phase_left = $urandom_range(50, 400);
      end else begin
        phase_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        if ($urandom_range(0, 49) == 0) stall_left = $urandom_range(20, 120);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycles, expected_medians.size());
    $display("Verification failed");
    $finish;
  end

  // Reset, directed table, random runs, drain and verdict
  initial begin : stimulus
    sample_mode_t         mode;
    logic signed [DW-1:0] next_value;
    logic signed [DW-1:0] prev_value;
    logic signed [DW-1:0] run_base;
    int                   run_left;
    int                   pick;
    bit                   quiet;
    mode         = MODE_WIDE;
    prev_value   = '0;
    run_base     = '0;
    run_left     = 0;
    quiet        = 1'b0;
    held_count   = 0;
    fail_count   = 0;
    samples_sent = 0;
    results_seen = 0;
    full_results = 0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_sample_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      sender_gap($urandom_range(0, 1) == 0);
      send_sample(directed_rows[i].value, directed_rows[i].typed_in,
                  median_result_t'({directed_rows[i].median, directed_rows[i].full}));
    end

    // Random runs: each run keeps one shape of sample stream
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (run_left == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)       mode = MODE_WIDE;
        else if (pick < 6)  mode = MODE_NARROW;
        else if (pick == 6) mode = MODE_RISING;
        else if (pick == 7) mode = MODE_FALLING;
        else                mode = MODE_EXTREME;
        run_left   = $urandom_range(5, 40);
        quiet      = ($urandom_range(0, 3) == 0);
        run_base   = $urandom;
        prev_value = run_base;
      end
      run_left--;
      case (mode)
        MODE_WIDE:    next_value = $urandom;
        // many equal samples
        MODE_NARROW:  next_value = run_base + $urandom_range(0, 15);
        MODE_RISING:  next_value = prev_value + $urandom_range(0, 1000);
        // each sample steps down from the one before it, for long walks
        MODE_FALLING: next_value = prev_value - $urandom_range(0, 1000);
        default: begin
          case ($urandom_range(0, 6))
            0:       next_value = 32'sh8000_0000;
            1:       next_value = 32'sh8000_0001;
            2:       next_value = -32'sd1;
            3:       next_value = 32'sh0000_0000;
            4:       next_value = 32'sd1;
            5:       next_value = 32'sh7fff_fffe;
            default: next_value = 32'sh7fff_ffff;
          endcase
        end
      endcase
      prev_value = next_value;
      sender_gap(quiet);
      send_sample(next_value, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_medians.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples, checked %0d medians, %0d of them with the store full.",
             samples_sent, results_seen, full_results);
    $display("Store reached %0d of %0d entries; %0d mismatches.",
             held_count, CAPACITY, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
